>>> design/adaptive_opcode_search_sequencer_top_defines.svh
// Assertion macros used by the port-level checker of the opcode search sequencer
`ifndef ADAPTIVE_OPCODE_SEARCH_SEQUENCER_TOP_DEFINES_SVH
`define ADAPTIVE_OPCODE_SEARCH_SEQUENCER_TOP_DEFINES_SVH

// Property checked outside reset
`define AOSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define AOSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/aoss_pkg.sv
// Types, constants and the skip classifier of the opcode search sequencer
package aoss_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned RATE_W  = 30;
    localparam int unsigned COUNT_W = 34;
    localparam int unsigned CLASS_W = 3;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    localparam logic [WORD_W-1:0]  START_WORD_RST = 32'h83C7777C;
    localparam logic [RATE_W-1:0]  RATE_ONE       = 30'd1;
    localparam logic [RATE_W-1:0]  RATE_BACK      = 30'd100;
    localparam logic [RATE_W-1:0]  RATE_MUL_LIMIT = 30'd100000000;
    localparam logic [RATE_W-1:0]  RATE_MAX       = 30'd1000000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    // Opcode field masks
    localparam logic [WORD_W-1:0] MASK_ANNUL = 32'hE1C00000;
    localparam logic [WORD_W-1:0] MASK_SETHI = 32'hFFC00000;
    localparam logic [WORD_W-1:0] MASK_OP3   = 32'hC1F80000;

    localparam logic [WORD_W-1:0] ANNUL_BA  = 32'h20800000;
    localparam logic [WORD_W-1:0] ANNUL_BB  = 32'h21800000;
    localparam logic [WORD_W-1:0] ANNUL_BC  = 32'h21C00000;
    localparam logic [WORD_W-1:0] SETHI_FP  = 32'h3D000000;
    localparam logic [WORD_W-1:0] SETHI_I7  = 32'h3F000000;
    localparam logic [WORD_W-1:0] OP_TADD   = 32'h81100000;
    localparam logic [WORD_W-1:0] OP_TSUB   = 32'h81180000;
    localparam logic [WORD_W-1:0] OP_WRY    = 32'h81800000;
    localparam logic [WORD_W-1:0] OP_WRPSR  = 32'h81880000;
    localparam logic [WORD_W-1:0] OP_WRWIM  = 32'h81900000;
    localparam logic [WORD_W-1:0] OP_WRTBR  = 32'h81980000;
    localparam logic [WORD_W-1:0] OP_REST   = 32'h81E80000;
    localparam logic [WORD_W-1:0] OP_SAVE   = 32'h81E00000;
    localparam logic [WORD_W-1:0] OP_RETT   = 32'h81C80000;
    localparam logic [WORD_W-1:0] OP_JMPL   = 32'h81C00000;
    localparam logic [WORD_W-1:0] OP_UDIV   = 32'h80700000;
    localparam logic [WORD_W-1:0] OP_SDIV   = 32'h80780000;
    localparam logic [WORD_W-1:0] OP_UDIVCC = 32'h80F00000;
    localparam logic [WORD_W-1:0] OP_SDIVCC = 32'h80F80000;
    localparam logic [WORD_W-1:0] OP_TICC   = 32'h81D00000;

    typedef enum logic [CLASS_W-1:0] {
        SKIP_RUN,
        SKIP_ANNUL,
        SKIP_SETHI,
        SKIP_TAGGED,
        SKIP_WR_SPECIAL,
        SKIP_WINDOW,
        SKIP_DIV,
        SKIP_TRAP
    } t_skip_class;

    function automatic t_skip_class classify(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] an;
        logic [WORD_W-1:0] sh;
        logic [WORD_W-1:0] f3;
        t_skip_class       cls;
        an = w & MASK_ANNUL;
        sh = w & MASK_SETHI;
        f3 = w & MASK_OP3;
        priority if (an == ANNUL_BA || an == ANNUL_BB || an == ANNUL_BC) begin
            cls = SKIP_ANNUL;
        end else if (sh == SETHI_FP || sh == SETHI_I7) begin
            cls = SKIP_SETHI;
        end else if (f3 == OP_TADD || f3 == OP_TSUB) begin
            cls = SKIP_TAGGED;
        end else if (f3 == OP_WRY || f3 == OP_WRPSR || f3 == OP_WRWIM || f3 == OP_WRTBR) begin
            cls = SKIP_WR_SPECIAL;
        end else if (f3 == OP_REST || f3 == OP_SAVE || f3 == OP_RETT || f3 == OP_JMPL) begin
            cls = SKIP_WINDOW;
        end else if (f3 == OP_UDIV || f3 == OP_SDIV || f3 == OP_UDIVCC || f3 == OP_SDIVCC) begin
            cls = SKIP_DIV;
        end else if (f3 == OP_TICC) begin
            cls = SKIP_TRAP;
        end else begin
            cls = SKIP_RUN;
        end
        return cls;
    endfunction

endpackage

>>> design/aoss_in_if.sv
// Input channel: start or report items with the observed trap code
interface aoss_in_if;
    import aoss_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [WORD_W-1:0] trap_value;

    modport source (output valid, output func, output trap_value, input ready);
    modport sink   (input valid, input func, input trap_value, output ready);
endinterface

>>> design/aoss_out_if.sv
// Output channel: candidate word, skip class and done flag
interface aoss_out_if;
    import aoss_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  candidate;
    logic [CLASS_W-1:0] skip_class;
    logic               done_res;

    modport source (output valid, output candidate, output skip_class, output done_res,
                    input ready);
    modport sink   (input valid, input candidate, input skip_class, input done_res,
                    output ready);
endinterface

>>> design/adaptive_opcode_search_sequencer_top.sv
// Adaptive opcode search sequencer: input register, search step, result register
// An input is held in the input register and its result in the result register.
// Throughput: one item per cycle unless o_out stalls; the search state update,
// rate compare and candidate add all close in the single stage between registers.
// Reset (i_rst_n low, synchronous) empties both registers, clears the search
// state (rate 1, forward) and loads the default start word.
module adaptive_opcode_search_sequencer_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [aoss_pkg::WORD_W-1:0] i_cfg_wr_data,
    aoss_in_if.sink                  i_in,
    aoss_out_if.source               o_out
);
    import aoss_pkg::*;

    logic [WORD_W-1:0]  r_start_word;

    // input register
    logic               r_in_vld;
    logic               r_func;
    logic [WORD_W-1:0]  r_trap;

    // search state
    logic [WORD_W-1:0]  r_current, n_current;
    logic [WORD_W-1:0]  r_last, n_last;
    logic [RATE_W-1:0]  r_rate, n_rate;
    logic               r_going_back, n_going_back;
    logic [WORD_W-1:0]  r_switch, n_switch;
    logic [WORD_W-1:0]  r_prior_trap, n_prior_trap;
    logic               r_prior_vld, n_prior_vld;
    logic [COUNT_W-1:0] r_repeat, n_repeat;
    logic               r_started, n_started;

    // result register
    logic               r_out_vld;
    logic [WORD_W-1:0]  r_cand, n_cand;
    logic [CLASS_W-1:0] r_class, n_class;
    logic               r_done, n_done;

    logic               out_free;
    logic               advance;
    logic [WORD_W-1:0]  pt;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] rate_x10;
    logic [WORD_W:0]    step_sum;
    logic [WORD_W-1:0]  step_diff;
    logic               step_ovf;
    logic [WORD_W-1:0]  step_next;

    assign out_free   = !r_out_vld || o_out.ready;
    assign advance    = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;

    assign o_out.valid      = r_out_vld;
    assign o_out.candidate  = r_cand;
    assign o_out.skip_class = r_class;
    assign o_out.done_res   = r_done;

    assign rate_x10 = ({{(COUNT_W-RATE_W){1'b0}}, r_rate} << 3)
                    + ({{(COUNT_W-RATE_W){1'b0}}, r_rate} << 1);
    assign cnt_inc  = (r_repeat == COUNT_MAX) ? r_repeat : r_repeat + {{(COUNT_W-1){1'b0}}, 1'b1};
    assign pt       = r_prior_vld ? r_prior_trap : r_trap;

    always_comb begin
        n_current    = r_current;
        n_last       = r_last;
        n_rate       = r_rate;
        n_going_back = r_going_back;
        n_switch     = r_switch;
        n_prior_trap = r_prior_trap;
        n_prior_vld  = r_prior_vld;
        n_repeat     = r_repeat;
        n_started    = r_started;
        n_cand       = '0;
        n_class      = SKIP_RUN;
        n_done       = 1'b0;
        step_sum     = '0;
        step_diff    = '0;
        step_ovf     = 1'b0;
        step_next    = '0;
        if (r_func == FUNC_START || !r_started) begin
            // restart the search at the configured word
            n_current    = r_start_word;
            n_last       = r_start_word;
            n_rate       = RATE_ONE;
            n_going_back = 1'b0;
            n_switch     = '0;
            n_prior_trap = '0;
            n_prior_vld  = 1'b0;
            n_repeat     = '0;
            n_started    = 1'b1;
            n_cand       = r_start_word;
            n_class      = classify(r_start_word);
        end else begin
            n_prior_vld  = 1'b1;
            n_prior_trap = pt;
            if (r_trap == pt) begin
                n_repeat = cnt_inc;
                if (!r_going_back && cnt_inc >= rate_x10) begin
                    n_rate   = (r_rate > RATE_MUL_LIMIT) ? RATE_MAX : rate_x10[RATE_W-1:0];
                    n_repeat = '0;
                end
            end else begin
                n_repeat     = '0;
                n_prior_trap = r_trap;
                if (!r_going_back) begin
                    // new code going forward: remember where and turn back
                    n_switch     = r_current;
                    n_going_back = 1'b1;
                    n_rate       = RATE_BACK;
                end else begin
                    n_current    = r_switch;
                    n_going_back = 1'b0;
                    n_prior_vld  = 1'b0;
                    n_rate       = RATE_ONE;
                end
            end

            step_sum  = {1'b0, n_current} + {{(WORD_W+1-RATE_W){1'b0}}, n_rate};
            step_diff = n_current - {{(WORD_W-RATE_W){1'b0}}, n_rate};
            if (n_going_back) begin
                step_ovf  = {{(WORD_W-RATE_W){1'b0}}, n_rate} > n_current;
                step_next = step_diff;
            end else begin
                step_ovf  = step_sum[WORD_W];
                step_next = step_sum[WORD_W-1:0];
            end
            n_current = step_next;

            if (step_ovf) begin
                if (n_rate > RATE_ONE) begin
                    // fall back to the last word at rate one
                    n_current = r_last;
                    n_rate    = RATE_ONE;
                    n_repeat  = '0;
                    n_cand    = r_last;
                    n_class   = classify(r_last);
                end else begin
                    n_done = 1'b1;
                end
            end else begin
                n_last  = step_next;
                n_cand  = step_next;
                n_class = classify(step_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_word <= START_WORD_RST;
        end else if (i_cfg_wr_en) begin
            r_start_word <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_trap <= i_in.trap_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current    <= '0;
            r_last       <= '0;
            r_rate       <= RATE_ONE;
            r_going_back <= 1'b0;
            r_switch     <= '0;
            r_prior_trap <= '0;
            r_prior_vld  <= 1'b0;
            r_repeat     <= '0;
            r_started    <= 1'b0;
        end else if (advance) begin
            r_current    <= n_current;
            r_last       <= n_last;
            r_rate       <= n_rate;
            r_going_back <= n_going_back;
            r_switch     <= n_switch;
            r_prior_trap <= n_prior_trap;
            r_prior_vld  <= n_prior_vld;
            r_repeat     <= n_repeat;
            r_started    <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cand  <= n_cand;
            r_class <= n_class;
            r_done  <= n_done;
        end
    end

endmodule

>>> design/aoss_checker.sv
// Port-level checker for the opcode search sequencer and its bind
`include "adaptive_opcode_search_sequencer_top_defines.svh"

module aoss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [aoss_pkg::WORD_W-1:0]  i_candidate,
    input logic [aoss_pkg::CLASS_W-1:0] i_skip_class,
    input logic                         i_done_res
);
    import aoss_pkg::*;

    // reset empties the result register
    `AOSS_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    // exhausted search carries an empty word and the run class
    `AOSS_ASSERT(a_done_payload, i_clk, i_rst_n, (i_out_valid && i_done_res) |-> (i_candidate == '0 && i_skip_class == SKIP_RUN), "done result with nonzero payload")
    `AOSS_ASSERT(a_valid_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")
    `AOSS_ASSERT(a_payload_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_candidate) && $stable(i_skip_class) && $stable(i_done_res)), "result changed while stalled")

endmodule

bind adaptive_opcode_search_sequencer_top aoss_checker u_aoss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_candidate  (o_out.candidate),
    .i_skip_class (o_out.skip_class),
    .i_done_res   (o_out.done_res)
);

>>> bench/aoss_search_checker.sv
// Checker for the opcode search sequencer: tracks the search state and compares every candidate
`timescale 1ns / 1ps

module aoss_search_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [aoss_pkg::WORD_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_in_func,
    input  logic [aoss_pkg::WORD_W-1:0]  i_in_trap_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [aoss_pkg::WORD_W-1:0]  i_out_candidate,
    input  logic [aoss_pkg::CLASS_W-1:0] i_out_skip_class,
    input  logic                         i_out_done_res,
    output int                           o_fail_count,
    output int                           o_pending
);
    import aoss_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_skip_class       cls;
        logic              done;
    } t_candidate;

    t_candidate pending_candidates[$];

    // Shadow copy of the search state
    logic [WORD_W-1:0]  start_word;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  last_word;
    logic [WORD_W-1:0]  switch_word;
    logic [WORD_W-1:0]  prior_code;
    logic [RATE_W-1:0]  rate;
    logic [COUNT_W-1:0] repeats;
    logic               backward;
    logic               prior_seen;
    logic               searching;

    function automatic t_skip_class skip_class_of(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] branch_bits;
        logic [WORD_W-1:0] sethi_bits;
        logic [WORD_W-1:0] op3_bits;
        t_skip_class       c;
        branch_bits = w & MASK_ANNUL;
        sethi_bits  = w & MASK_SETHI;
        op3_bits    = w & MASK_OP3;
        c = SKIP_RUN;
        // Lowest priority first, later matches win
        case (op3_bits)
            OP_TICC:                              c = SKIP_TRAP;
            OP_UDIV, OP_SDIV, OP_UDIVCC, OP_SDIVCC: c = SKIP_DIV;
            OP_REST, OP_SAVE, OP_RETT, OP_JMPL:   c = SKIP_WINDOW;
            OP_WRY, OP_WRPSR, OP_WRWIM, OP_WRTBR: c = SKIP_WR_SPECIAL;
            OP_TADD, OP_TSUB:                     c = SKIP_TAGGED;
            default: ;
        endcase
        if (sethi_bits == SETHI_FP || sethi_bits == SETHI_I7) c = SKIP_SETHI;
        if (branch_bits == ANNUL_BA || branch_bits == ANNUL_BB || branch_bits == ANNUL_BC) begin
            c = SKIP_ANNUL;
        end
        return c;
    endfunction

    function automatic void restart_search();
        cur_word    = '0;
        last_word   = '0;
        switch_word = '0;
        prior_code  = '0;
        rate        = RATE_ONE;
        repeats     = '0;
        backward    = 1'b0;
        prior_seen  = 1'b0;
        searching   = 1'b0;
    endfunction

    function automatic t_candidate next_candidate(input logic func,
                                                  input logic [WORD_W-1:0] code);
        logic [WORD_W:0]   sum;
        logic [WORD_W-1:0] nxt;
        logic              wrap;
        if (func == FUNC_START || !searching) begin
            restart_search();
            searching = 1'b1;
            cur_word  = start_word;
            last_word = start_word;
            return '{start_word, skip_class_of(start_word), 1'b0};
        end

        if (!prior_seen) begin
            prior_code = code;
            prior_seen = 1'b1;
        end
        if (code == prior_code) begin
            if (repeats != COUNT_MAX) repeats++;
            // Speed up only while heading forward
            if (!backward && repeats >= 34'(rate) * 34'd10) begin
                rate    = (rate > RATE_MUL_LIMIT) ? RATE_MAX : rate * 30'd10;
                repeats = '0;
            end
        end else begin
            repeats    = '0;
            prior_code = code;
            if (!backward) begin
                switch_word = cur_word;
                backward    = 1'b1;
                rate        = RATE_BACK;
            end else begin
                cur_word   = switch_word;
                backward   = 1'b0;
                prior_seen = 1'b0;
                rate       = RATE_ONE;
            end
        end

        if (!backward) begin
            sum  = {1'b0, cur_word} + 33'(rate);
            nxt  = sum[WORD_W-1:0];
            wrap = sum[WORD_W];
        end else begin
            nxt  = cur_word - 32'(rate);
            wrap = 32'(rate) > cur_word;
        end
        cur_word = nxt;

        if (wrap) begin
            if (rate > RATE_ONE) begin
                // Fall back to the last good word at unit rate
                cur_word = last_word;
                rate     = RATE_ONE;
                repeats  = '0;
                return '{last_word, skip_class_of(last_word), 1'b0};
            end
            return '{'0, SKIP_RUN, 1'b1};
        end
        last_word = nxt;
        return '{nxt, skip_class_of(nxt), 1'b0};
    endfunction

    always @(posedge i_clk) begin
        t_candidate got;
        t_candidate want;
        if (!i_rst_n) begin
            restart_search();
            start_word = START_WORD_RST;
            pending_candidates.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_candidate, t_skip_class'(i_out_skip_class), i_out_done_res};
                if (pending_candidates.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected transfer, expected none, got %h/%0d/%0b",
                             $time, got.word, got.cls, got.done);
                end else begin
                    want = pending_candidates.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: mismatch, expected %h/%0d/%0b, got %h/%0d/%0b",
                                 $time, want.word, want.cls, want.done,
                                 got.word, got.cls, got.done);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_candidates.push_back(next_candidate(i_in_func, i_in_trap_value));
            end
            if (i_cfg_wr_en) start_word = i_cfg_wr_data;
        end
        o_pending = pending_candidates.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

>>> bench/tb_top.sv
// Top of the opcode search sequencer bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import aoss_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [WORD_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending;
    int                cycle_count;
    int                items_sent;
    logic              gaps_on;
    logic              stalls_on;

    aoss_in_if  in_if ();
    aoss_out_if out_if ();

    adaptive_opcode_search_sequencer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_if),
        .o_out        (out_if)
    );

    aoss_search_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_if.valid),
        .i_in_ready      (in_if.ready),
        .i_in_func       (in_if.func),
        .i_in_trap_value (in_if.trap_value),
        .i_out_valid     (out_if.valid),
        .i_out_ready     (out_if.ready),
        .i_out_candidate (out_if.candidate),
        .i_out_skip_class(out_if.skip_class),
        .i_out_done_res  (out_if.done_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Result side back-pressure in bursts
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
        end
    end

    task automatic send_item(input logic func, input logic [WORD_W-1:0] code);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.func       = func;
        in_if.trap_value = code;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // Drain the block, then write the start word
    task automatic load_start_word(input logic [WORD_W-1:0] w);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        @(negedge i_clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_start_word();
        logic [WORD_W-1:0] fill;
        fill = $urandom;
        case ($urandom_range(0, 7))
            0, 1: return 32'hFFFFFFFF - $urandom_range(0, 400);
            2:    return $urandom_range(0, 400);
            3, 4: begin
                case ($urandom_range(0, 7))
                    0: return ANNUL_BC  | (fill & ~MASK_ANNUL);
                    1: return SETHI_FP  | (fill & ~MASK_SETHI);
                    2: return SETHI_I7  | (fill & ~MASK_SETHI);
                    3: return OP_TSUB   | (fill & ~MASK_OP3);
                    4: return OP_WRTBR  | (fill & ~MASK_OP3);
                    5: return OP_SAVE   | (fill & ~MASK_OP3);
                    6: return OP_SDIVCC | (fill & ~MASK_OP3);
                    default: return OP_TICC | (fill & ~MASK_OP3);
                endcase
            end
            default: return fill;
        endcase
    endfunction

    initial begin
        int                random_base;
        int                len;
        int                change_pct;
        int                roll;
        logic [WORD_W-1:0] code;

        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_START;
        in_if.trap_value = '0;
        items_sent       = 0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Report before any start acts as a start with the default word
        send_item(FUNC_REPORT, 32'hFFFFFFFF);
        send_item(FUNC_START, 32'h0);
        send_item(FUNC_REPORT, 32'h0);
        send_item(FUNC_REPORT, 32'h0);
        send_item(FUNC_REPORT, 32'hFFFFFFFF);
        send_item(FUNC_REPORT, 32'h0);

        // Rate reaches ten near the top, wraps, falls back, then runs out
        load_start_word(32'hFFFFFFF4);
        send_item(FUNC_START, 32'h0);
        repeat (14) send_item(FUNC_REPORT, 32'h00000100);

        // Backward wrap at rate 100, then at rate 1, then return to the switch point
        load_start_word(32'h0);
        send_item(FUNC_START, 32'h0);
        send_item(FUNC_REPORT, 32'h00001234);
        repeat (3) send_item(FUNC_REPORT, 32'h00005678);
        send_item(FUNC_REPORT, 32'h00009ABC);

        load_start_word(32'hFFFFFFFF);
        send_item(FUNC_START, 32'h0);
        send_item(FUNC_REPORT, 32'h0);

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            if (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 2) != 0);
                stalls_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 4) != 0) load_start_word(pick_start_word());
            case ($urandom_range(0, 3))
                0:       change_pct = 0;
                1:       change_pct = 2;
                2:       change_pct = 10;
                default: change_pct = 30;
            endcase
            // Mostly fresh searches; some keep going from where the last one stopped
            send_item(($urandom_range(0, 9) == 0) ? FUNC_REPORT : FUNC_START, $urandom);
            code = $urandom;
            len  = $urandom_range(4, 120);
            for (int i = 0; i < len; i++) begin
                if (items_sent - random_base >= RANDOM_ITEMS) break;
                // Drop idling for the tail of the run
                if (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS) begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                roll = $urandom_range(0, 99);
                if (roll < change_pct) code = $urandom;
                send_item((roll == 99) ? FUNC_START : FUNC_REPORT, code);
            end
        end

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
